/* sv/segdsl_pkg.sv */
package segdsl_pkg;

    // input item command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_FIRST_X     = 3'd0;
    localparam logic [2:0] CFG_FIRST_Y     = 3'd1;
    localparam logic [2:0] CFG_FIRST_Z     = 3'd2;
    localparam logic [2:0] CFG_SECOND_X    = 3'd3;
    localparam logic [2:0] CFG_SECOND_Y    = 3'd4;
    localparam logic [2:0] CFG_SECOND_Z    = 3'd5;
    localparam logic [2:0] CFG_LAYER_COUNT = 3'd6;

    localparam logic [31:0] NO_LIMIT = 32'hFFFF_FFFF;

    // datapath widths
    localparam int DIFF_W = 33;   // coordinate difference
    localparam int MUL_W  = 34;   // multiplier operand
    localparam int PROD_W = 68;   // multiplier product
    localparam int SQ_W   = 66;   // sum of three squares
    localparam int DOT_W  = 68;   // signed dot product
    localparam int BIG_W  = 132;  // dividend / quotient shift register
    localparam int RAD_W  = 68;   // square root radicand
    localparam int ROOT_W = 34;   // distance
    localparam int SREM_W = 37;   // square root remainder

    // iteration counts
    localparam int MUL_STEPS  = 12;
    localparam int SQ_STEPS   = RAD_W / 2;
    localparam int DIV_MAP_N  = 64;
    localparam int DIV_PERP_N = BIG_W;
    localparam int DOT_STEPS  = 3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHK,
        ST_SQ_INIT,
        ST_SQ_RUN,
        ST_MAP_RD0,
        ST_MAP_C0,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_LO_RD,
        ST_LO_CAP,
        ST_IMUL,
        ST_IMUL_W,
        ST_DIV_MAP,
        ST_MAP_FIN,
        ST_DOT_CLR,
        ST_DOT_MUL,
        ST_DIV_PERP,
        ST_DONE
    } t_state;

    // multiplier operations; the first twelve run in counter order
    typedef enum logic [3:0] {
        MOP_VX2,
        MOP_VY2,
        MOP_VZ2,
        MOP_UX2,
        MOP_UY2,
        MOP_UZ2,
        MOP_WX2,
        MOP_WY2,
        MOP_WZ2,
        MOP_VWX,
        MOP_VWY,
        MOP_VWZ,
        MOP_DLL,
        MOP_DLH,
        MOP_DHH,
        MOP_INTERP
    } t_mop;

    typedef enum logic [1:0] {
        SRC_VV,
        SRC_UU,
        SRC_PERP
    } t_src;

    typedef enum logic {
        DIV_SPAN,
        DIV_WW
    } t_div_sel;

    typedef enum logic [1:0] {
        VAL_E0,
        VAL_NOLIMIT,
        VAL_INTERP
    } t_val;

    typedef struct packed {
        logic     load_point;
        logic     clr_acc;
        logic     clr_big;
        logic     tbl_we;
        logic     mul_en;
        t_mop     mop;
        logic     div_init;
        t_div_sel div_sel;
        logic     div_step;
        logic     sq_init;
        t_src     sq_sel;
        logic     sq_step;
        logic     cap_lo;
        logic     cap_hi;
        logic     best_upd;
        logic     best_init;
        t_val     val_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic d_le_r;
        logic perp_ok;
    } t_dp_status;

endpackage

/* sv/segdsl_ctrl.sv */
module segdsl_ctrl #(
    parameter int LIDX_W = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  logic                   i_command,
    input  segdsl_pkg::t_dp_status i_status,
    input  logic [LIDX_W-1:0]      i_n_m1,
    output segdsl_pkg::t_dp_cmd    o_cmd,
    output logic [LIDX_W-1:0]      o_addr,
    output logic                   busy,
    output logic                   o_valid
);

    segdsl_pkg::t_state r_state, n_state;
    segdsl_pkg::t_src   r_src, n_src;
    logic [7:0]         r_cnt, n_cnt;
    logic [LIDX_W-1:0]  r_idx, n_idx;
    logic               r_found, n_found;
    logic               r_perp, n_perp;

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= segdsl_pkg::ST_IDLE;
            r_src   <= segdsl_pkg::SRC_VV;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_found <= 1'b0;
            r_perp  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_src   <= n_src;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_found <= n_found;
            r_perp  <= n_perp;
        end
    end

    assign busy    = (r_state != segdsl_pkg::ST_IDLE);
    assign o_valid = (r_state == segdsl_pkg::ST_DONE);

    // next state and datapath commands
    always_comb begin
        segdsl_pkg::t_state after_map;
        segdsl_pkg::t_src   after_src;

        n_state = r_state;
        n_src   = r_src;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_found = r_found;
        n_perp  = r_perp;
        o_addr  = '0;
        o_cmd   = '0;
        o_cmd.best_init = (r_src == segdsl_pkg::SRC_VV);

        // where to go once a distance has been mapped
        after_map = segdsl_pkg::ST_DONE;
        after_src = r_src;
        case (r_src)
            segdsl_pkg::SRC_VV: begin
                after_map = segdsl_pkg::ST_SQ_INIT;
                after_src = segdsl_pkg::SRC_UU;
            end
            segdsl_pkg::SRC_UU: begin
                after_map = r_perp ? segdsl_pkg::ST_DOT_CLR : segdsl_pkg::ST_DONE;
            end
            default: after_map = segdsl_pkg::ST_DONE;
        endcase

        case (r_state)
            segdsl_pkg::ST_IDLE: begin
                if (start) begin
                    if (i_command == segdsl_pkg::CMD_QUERY) begin
                        o_cmd.load_point = 1'b1;
                        o_cmd.clr_acc    = 1'b1;
                        n_cnt   = '0;
                        n_src   = segdsl_pkg::SRC_VV;
                        n_state = segdsl_pkg::ST_MUL;
                    end else begin
                        o_cmd.tbl_we = 1'b1;
                    end
                end
            end
            // squares and dot product, pipelined one product a cycle
            segdsl_pkg::ST_MUL: begin
                if (r_cnt < 8'(segdsl_pkg::MUL_STEPS)) begin
                    o_cmd.mul_en = 1'b1;
                    o_cmd.mop    = segdsl_pkg::t_mop'(r_cnt[3:0]);
                    n_cnt        = r_cnt + 8'd1;
                end else begin
                    n_state = segdsl_pkg::ST_CHK;
                end
            end
            segdsl_pkg::ST_CHK: begin
                n_perp  = i_status.perp_ok;
                n_state = segdsl_pkg::ST_SQ_INIT;
            end
            segdsl_pkg::ST_SQ_INIT: begin
                o_cmd.sq_init = 1'b1;
                o_cmd.sq_sel  = r_src;
                n_cnt         = '0;
                n_state       = segdsl_pkg::ST_SQ_RUN;
            end
            segdsl_pkg::ST_SQ_RUN: begin
                o_cmd.sq_step = 1'b1;
                n_cnt         = r_cnt + 8'd1;
                if (r_cnt == 8'(segdsl_pkg::SQ_STEPS - 1)) begin
                    n_state = segdsl_pkg::ST_MAP_RD0;
                end
            end
            segdsl_pkg::ST_MAP_RD0: begin
                n_state = segdsl_pkg::ST_MAP_C0;
            end
            // inside the first radius, no limit when at most one layer is in use, or start the walk from the top layer
            segdsl_pkg::ST_MAP_C0: begin
                if (i_status.d_le_r) begin
                    o_cmd.best_upd = 1'b1;
                    o_cmd.val_sel  = segdsl_pkg::VAL_E0;
                    n_state        = after_map;
                    n_src          = after_src;
                end else if (i_n_m1 == '0) begin
                    o_cmd.best_upd = 1'b1;
                    o_cmd.val_sel  = segdsl_pkg::VAL_NOLIMIT;
                    n_state        = after_map;
                    n_src          = after_src;
                end else begin
                    n_idx   = i_n_m1;
                    n_found = 1'b0;
                    n_state = segdsl_pkg::ST_WALK_RD;
                end
            end
            segdsl_pkg::ST_WALK_RD: begin
                o_addr  = r_idx;
                n_state = segdsl_pkg::ST_WALK_CMP;
            end
            segdsl_pkg::ST_WALK_CMP: begin
                if (i_status.d_le_r) begin
                    o_cmd.cap_hi = 1'b1;
                    n_found      = 1'b1;
                    if (r_idx == LIDX_W'(1)) begin
                        n_state = segdsl_pkg::ST_LO_RD;
                    end else begin
                        n_idx   = r_idx - LIDX_W'(1);
                        n_state = segdsl_pkg::ST_WALK_RD;
                    end
                end else if (r_found) begin
                    // the failing layer is the lower bound of the selected one
                    o_cmd.cap_lo = 1'b1;
                    n_state      = segdsl_pkg::ST_IMUL;
                end else begin
                    o_cmd.best_upd = 1'b1;
                    o_cmd.val_sel  = segdsl_pkg::VAL_NOLIMIT;
                    n_state        = after_map;
                    n_src          = after_src;
                end
            end
            segdsl_pkg::ST_LO_RD: begin
                n_state = segdsl_pkg::ST_LO_CAP;
            end
            segdsl_pkg::ST_LO_CAP: begin
                o_cmd.cap_lo = 1'b1;
                n_state      = segdsl_pkg::ST_IMUL;
            end
            // interpolation: product, then shared divider
            segdsl_pkg::ST_IMUL: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mop      = segdsl_pkg::MOP_INTERP;
                o_cmd.div_init = 1'b1;
                o_cmd.div_sel  = segdsl_pkg::DIV_SPAN;
                n_state        = segdsl_pkg::ST_IMUL_W;
            end
            segdsl_pkg::ST_IMUL_W: begin
                n_cnt   = '0;
                n_state = segdsl_pkg::ST_DIV_MAP;
            end
            segdsl_pkg::ST_DIV_MAP: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 8'd1;
                if (r_cnt == 8'(segdsl_pkg::DIV_MAP_N - 1)) begin
                    n_state = segdsl_pkg::ST_MAP_FIN;
                end
            end
            segdsl_pkg::ST_MAP_FIN: begin
                o_cmd.best_upd = 1'b1;
                o_cmd.val_sel  = segdsl_pkg::VAL_INTERP;
                n_state        = after_map;
                n_src          = after_src;
            end
            // perpendicular term: dot squared over |w|^2
            segdsl_pkg::ST_DOT_CLR: begin
                o_cmd.clr_big = 1'b1;
                n_cnt         = '0;
                n_src         = segdsl_pkg::SRC_PERP;
                n_state       = segdsl_pkg::ST_DOT_MUL;
            end
            segdsl_pkg::ST_DOT_MUL: begin
                n_cnt = r_cnt + 8'd1;
                case (r_cnt)
                    8'd0: begin
                        o_cmd.mul_en   = 1'b1;
                        o_cmd.mop      = segdsl_pkg::MOP_DLL;
                        o_cmd.div_init = 1'b1;
                        o_cmd.div_sel  = segdsl_pkg::DIV_WW;
                    end
                    8'd1: begin
                        o_cmd.mul_en = 1'b1;
                        o_cmd.mop    = segdsl_pkg::MOP_DLH;
                    end
                    8'd2: begin
                        o_cmd.mul_en = 1'b1;
                        o_cmd.mop    = segdsl_pkg::MOP_DHH;
                    end
                    default: begin
                        n_cnt   = '0;
                        n_state = segdsl_pkg::ST_DIV_PERP;
                    end
                endcase
            end
            segdsl_pkg::ST_DIV_PERP: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 8'd1;
                if (r_cnt == 8'(segdsl_pkg::DIV_PERP_N - 1)) begin
                    n_state = segdsl_pkg::ST_SQ_INIT;
                end
            end
            segdsl_pkg::ST_DONE: begin
                n_state = segdsl_pkg::ST_IDLE;
            end
            default: n_state = segdsl_pkg::ST_IDLE;
        endcase
    end

endmodule

/* sv/segdsl_dp.sv */
module segdsl_dp #(
    parameter int MAX_LAYERS = 8,
    parameter int LIDX_W     = 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  segdsl_pkg::t_dp_cmd       i_cmd,
    input  logic [LIDX_W-1:0]         i_addr,
    output segdsl_pkg::t_dp_status    o_status,
    output logic [LIDX_W-1:0]         o_n_m1,
    input  logic                      i_cfg_we,
    input  logic [2:0]                i_cfg_idx,
    input  logic [31:0]               i_cfg_data,
    input  logic [2:0]                i_layer_index,
    input  logic [31:0]               i_layer_radius,
    input  logic [31:0]               i_layer_edge,
    input  logic signed [31:0]        i_point_x,
    input  logic signed [31:0]        i_point_y,
    input  logic signed [31:0]        i_point_z,
    output logic [31:0]               o_edge_length
);

    localparam int DW = segdsl_pkg::DIFF_W;
    localparam int MW = segdsl_pkg::MUL_W;
    localparam int PW = segdsl_pkg::PROD_W;
    localparam int SW = segdsl_pkg::SQ_W;
    localparam int BW = segdsl_pkg::BIG_W;
    localparam int RW = segdsl_pkg::RAD_W;
    localparam int TW = segdsl_pkg::ROOT_W;
    localparam int EW = segdsl_pkg::SREM_W;

    // configuration registers
    logic signed [31:0] r_e0x, r_e0y, r_e0z, r_e1x, r_e1y, r_e1z;
    logic [3:0]         r_lc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0x <= '0;
            r_e0y <= '0;
            r_e0z <= '0;
            r_e1x <= '0;
            r_e1y <= '0;
            r_e1z <= '0;
            r_lc  <= 4'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                segdsl_pkg::CFG_FIRST_X:     r_e0x <= i_cfg_data;
                segdsl_pkg::CFG_FIRST_Y:     r_e0y <= i_cfg_data;
                segdsl_pkg::CFG_FIRST_Z:     r_e0z <= i_cfg_data;
                segdsl_pkg::CFG_SECOND_X:    r_e1x <= i_cfg_data;
                segdsl_pkg::CFG_SECOND_Y:    r_e1y <= i_cfg_data;
                segdsl_pkg::CFG_SECOND_Z:    r_e1z <= i_cfg_data;
                segdsl_pkg::CFG_LAYER_COUNT: r_lc  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // layers in use, minus one, clamped to the table
    always_comb begin
        if (r_lc == 4'd0) begin
            o_n_m1 = '0;
        end else if (32'(r_lc) > MAX_LAYERS) begin
            o_n_m1 = LIDX_W'(MAX_LAYERS - 1);
        end else begin
            o_n_m1 = LIDX_W'(r_lc - 4'd1);
        end
    end

    // layer table, one registered read port
    logic [31:0]             r_rtab [MAX_LAYERS];
    logic [31:0]             r_etab [MAX_LAYERS];
    logic [31:0]             r_rd_r, r_rd_e;
    logic [LIDX_W+2:0]       widx;

    assign widx = (LIDX_W + 3)'(i_layer_index);

    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_we && (32'(i_layer_index) < MAX_LAYERS)) begin
            r_rtab[widx[LIDX_W-1:0]] <= i_layer_radius;
            r_etab[widx[LIDX_W-1:0]] <= i_layer_edge;
        end
        r_rd_r <= r_rtab[i_addr];
        r_rd_e <= r_etab[i_addr];
    end

    // coordinate differences
    logic signed [DW-1:0] r_vx, r_vy, r_vz, r_ux, r_uy, r_uz, r_wx, r_wy, r_wz;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_point) begin
            r_vx <= DW'(i_point_x) - DW'(r_e0x);
            r_vy <= DW'(i_point_y) - DW'(r_e0y);
            r_vz <= DW'(i_point_z) - DW'(r_e0z);
            r_ux <= DW'(i_point_x) - DW'(r_e1x);
            r_uy <= DW'(i_point_y) - DW'(r_e1y);
            r_uz <= DW'(i_point_z) - DW'(r_e1z);
            r_wx <= DW'(r_e1x) - DW'(r_e0x);
            r_wy <= DW'(r_e1y) - DW'(r_e0y);
            r_wz <= DW'(r_e1z) - DW'(r_e0z);
        end
    end

    // accumulators, divider and root registers
    logic [SW-1:0]                 r_vv, r_uu, r_ww;
    logic signed [segdsl_pkg::DOT_W-1:0] r_dot;
    logic [BW-1:0]                 r_big;
    logic [SW-1:0]                 r_rem, r_dvs;
    logic [RW-1:0]                 r_rad;
    logic [TW-1:0]                 r_root;
    logic [EW-1:0]                 r_srem;
    logic [31:0]                   r_lo_r, r_lo_e, r_hi_r, r_hi_e;
    logic [31:0]                   r_best;
    logic signed [PW-1:0]          r_prod;
    segdsl_pkg::t_mop              r_prod_op;
    logic                          r_prod_vld;

    // multiplier operand select
    logic signed [MW-1:0] ma, mb;
    logic [31:0]          de, off;
    logic [32:0]          d_lo, d_hi;

    assign d_lo = r_dot[32:0];
    assign d_hi = r_dot[65:33];
    assign de   = (r_hi_e >= r_lo_e) ? (r_hi_e - r_lo_e) : (r_lo_e - r_hi_e);
    assign off  = r_root[31:0] - r_lo_r;

    always_comb begin
        case (i_cmd.mop)
            segdsl_pkg::MOP_VX2: begin ma = MW'(r_vx); mb = MW'(r_vx); end
            segdsl_pkg::MOP_VY2: begin ma = MW'(r_vy); mb = MW'(r_vy); end
            segdsl_pkg::MOP_VZ2: begin ma = MW'(r_vz); mb = MW'(r_vz); end
            segdsl_pkg::MOP_UX2: begin ma = MW'(r_ux); mb = MW'(r_ux); end
            segdsl_pkg::MOP_UY2: begin ma = MW'(r_uy); mb = MW'(r_uy); end
            segdsl_pkg::MOP_UZ2: begin ma = MW'(r_uz); mb = MW'(r_uz); end
            segdsl_pkg::MOP_WX2: begin ma = MW'(r_wx); mb = MW'(r_wx); end
            segdsl_pkg::MOP_WY2: begin ma = MW'(r_wy); mb = MW'(r_wy); end
            segdsl_pkg::MOP_WZ2: begin ma = MW'(r_wz); mb = MW'(r_wz); end
            segdsl_pkg::MOP_VWX: begin ma = MW'(r_vx); mb = MW'(r_wx); end
            segdsl_pkg::MOP_VWY: begin ma = MW'(r_vy); mb = MW'(r_wy); end
            segdsl_pkg::MOP_VWZ: begin ma = MW'(r_vz); mb = MW'(r_wz); end
            segdsl_pkg::MOP_DLL: begin ma = {1'b0, d_lo}; mb = {1'b0, d_lo}; end
            segdsl_pkg::MOP_DLH: begin ma = {1'b0, d_lo}; mb = {1'b0, d_hi}; end
            segdsl_pkg::MOP_DHH: begin ma = {1'b0, d_hi}; mb = {1'b0, d_hi}; end
            segdsl_pkg::MOP_INTERP: begin ma = {2'b0, de}; mb = {2'b0, off}; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    // multiplier stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mul_en;
        end
        r_prod    <= ma * mb;
        r_prod_op <= i_cmd.mop;
    end

    // divider step: restoring, one quotient bit a cycle
    logic [SW:0] div_sh;
    logic        div_ge;

    assign div_sh = {r_rem, r_big[BW-1]};
    assign div_ge = (div_sh >= {1'b0, r_dvs});

    // square root step: two radicand bits a cycle
    logic [EW+1:0] sq_sh, sq_trial;
    logic          sq_ge;
    logic [SW-1:0] perp_sq;

    assign sq_sh    = {r_srem, r_rad[RW-1:RW-2]};
    assign sq_trial = {3'b0, r_root, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);
    assign perp_sq  = r_vv - r_big[SW-1:0] - SW'(r_rem != '0);

    // accumulate products, drive divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_acc) begin
            r_vv  <= '0;
            r_uu  <= '0;
            r_ww  <= '0;
            r_dot <= '0;
        end else if (r_prod_vld) begin
            case (r_prod_op)
                segdsl_pkg::MOP_VX2, segdsl_pkg::MOP_VY2, segdsl_pkg::MOP_VZ2:
                    r_vv <= r_vv + r_prod[SW-1:0];
                segdsl_pkg::MOP_UX2, segdsl_pkg::MOP_UY2, segdsl_pkg::MOP_UZ2:
                    r_uu <= r_uu + r_prod[SW-1:0];
                segdsl_pkg::MOP_WX2, segdsl_pkg::MOP_WY2, segdsl_pkg::MOP_WZ2:
                    r_ww <= r_ww + r_prod[SW-1:0];
                segdsl_pkg::MOP_VWX, segdsl_pkg::MOP_VWY, segdsl_pkg::MOP_VWZ:
                    r_dot <= r_dot + r_prod;
                default: ;
            endcase
        end

        if (i_cmd.clr_big) begin
            r_big <= '0;
        end else if (r_prod_vld && (r_prod_op == segdsl_pkg::MOP_DLL)) begin
            r_big <= r_big + BW'(unsigned'(r_prod));
        end else if (r_prod_vld && (r_prod_op == segdsl_pkg::MOP_DLH)) begin
            r_big <= r_big + (BW'(unsigned'(r_prod)) << 34);
        end else if (r_prod_vld && (r_prod_op == segdsl_pkg::MOP_DHH)) begin
            r_big <= r_big + (BW'(unsigned'(r_prod)) << 66);
        end else if (r_prod_vld && (r_prod_op == segdsl_pkg::MOP_INTERP)) begin
            // left-align the 64-bit dividend
            r_big <= {r_prod[63:0], (BW - 64)'(0)};
        end else if (i_cmd.div_step) begin
            r_big <= {r_big[BW-2:0], div_ge};
        end

        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_dvs <= (i_cmd.div_sel == segdsl_pkg::DIV_WW) ? r_ww
                                                           : SW'(r_hi_r - r_lo_r);
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? SW'(div_sh - {1'b0, r_dvs}) : div_sh[SW-1:0];
        end
    end

    // integer square root
    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_init) begin
            r_root <= '0;
            r_srem <= '0;
            case (i_cmd.sq_sel)
                segdsl_pkg::SRC_VV: r_rad <= RW'(r_vv);
                segdsl_pkg::SRC_UU: r_rad <= RW'(r_uu);
                default:            r_rad <= RW'(perp_sq);
            endcase
        end else if (i_cmd.sq_step) begin
            r_rad  <= {r_rad[RW-3:0], 2'b00};
            r_root <= {r_root[TW-2:0], sq_ge};
            r_srem <= sq_ge ? EW'(sq_sh - sq_trial) : sq_sh[EW-1:0];
        end
    end

    // table bounds for interpolation
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_lo) begin
            r_lo_r <= r_rd_r;
            r_lo_e <= r_rd_e;
        end
        if (i_cmd.cap_hi) begin
            r_hi_r <= r_rd_r;
            r_hi_e <= r_rd_e;
        end
    end

    // mapped value and running minimum
    logic [31:0] map_val;

    always_comb begin
        case (i_cmd.val_sel)
            segdsl_pkg::VAL_E0:     map_val = r_rd_e;
            segdsl_pkg::VAL_INTERP: map_val = (r_hi_e >= r_lo_e) ? (r_lo_e + r_big[31:0])
                                                                 : (r_lo_e - r_big[31:0]);
            default:                map_val = segdsl_pkg::NO_LIMIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.best_upd && (i_cmd.best_init || (map_val < r_best))) begin
            r_best <= map_val;
        end
    end

    assign o_edge_length    = r_best;
    assign o_status.d_le_r  = (r_root <= TW'(r_rd_r));
    assign o_status.perp_ok = (r_ww != '0) && !r_dot[segdsl_pkg::DOT_W-1]
                              && (unsigned'(r_dot) <= segdsl_pkg::DOT_W'(r_ww));

endmodule

/* sv/segment_distance_size_lookup.sv */
// Segment distance size lookup. Raise start with command, layer and point fields
// while busy is low. A load (command 0) writes one table layer at that edge, gives
// no result and leaves busy low. A query (command 1) raises busy, and the answer
// appears on o_edge_length with o_valid high for exactly one cycle; the receiver
// cannot stall it, so it must be taken in that cycle. The shared 34x34 multiplier
// forms the squares and dot products, followed by the projection check. Each
// distance needs a bit-serial integer square root, with setup and the first-layer
// check. The layer walk reads one layer at a time through the table's registered
// read port. An interpolation uses a restoring divider. When the point projects
// onto the segment, the perpendicular term runs through the divider before its
// own root and mapping. Configuration must be written only while idle; the user
// is bound to this, as the block itself does not enforce it.
module segment_distance_size_lookup #(
    parameter int MAX_LAYERS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_command,
    input  logic [2:0]         i_layer_index,
    input  logic [31:0]        i_layer_radius,
    input  logic [31:0]        i_layer_edge,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    output logic               o_valid,
    output logic [31:0]        o_edge_length
);

    localparam int LIDX_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

    segdsl_pkg::t_dp_cmd    dp_cmd;
    segdsl_pkg::t_dp_status dp_status;
    logic [LIDX_W-1:0]      tbl_addr;
    logic [LIDX_W-1:0]      n_m1;

    segdsl_ctrl #(
        .LIDX_W (LIDX_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .i_status  (dp_status),
        .i_n_m1    (n_m1),
        .o_cmd     (dp_cmd),
        .o_addr    (tbl_addr),
        .busy      (busy),
        .o_valid   (o_valid)
    );

    segdsl_dp #(
        .MAX_LAYERS (MAX_LAYERS),
        .LIDX_W     (LIDX_W)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_addr         (tbl_addr),
        .o_status       (dp_status),
        .o_n_m1         (n_m1),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_layer_index  (i_layer_index),
        .i_layer_radius (i_layer_radius),
        .i_layer_edge   (i_layer_edge),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .o_edge_length  (o_edge_length)
    );

endmodule
